>>> rtl/ids_pkg.sv
// ids_pkg: shared types, constants and the color scale of the image difference
// statistics block. No dependencies; used by every module in this folder.

package ids_pkg;

    // image and accumulator sizing
    localparam int MAX_PIXELS = 16777216;
    localparam int CHANNELS   = 3;
    localparam int COLORS     = 3;   // channels that carry image data (blue, green, red)
    localparam int NSLOT      = 4;   // largest channel count the record format knows

    localparam int PIX_W      = 8;
    localparam int SUM_W      = 32;
    localparam int SQ_W       = 40;
    localparam int CNT_W      = $clog2(MAX_PIXELS + 1);

    // result field widths
    localparam int REC_W      = 3;
    localparam int ESUM_W     = 34;
    localparam int SSUM_W     = 52;
    localparam int PTOT_W     = 25;

    localparam int IN_DATA_W  = 2 * COLORS * PIX_W;
    localparam int OUT_DATA_W = 152;

    localparam int LANE_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IDX_W      = $clog2(CHANNELS + 1);

    // record kinds
    localparam logic [REC_W-1:0] REC_PIXEL = 3'd0;
    localparam logic [REC_W-1:0] REC_BLUE  = 3'd1;
    localparam logic [REC_W-1:0] REC_GREEN = 3'd2;
    localparam logic [REC_W-1:0] REC_RED   = 3'd3;
    localparam logic [REC_W-1:0] REC_TOTAL = 3'd4;

    typedef struct packed {
        logic [PIX_W-1:0] err_min;
        logic [PIX_W-1:0] err_max;
        logic [SUM_W-1:0] err_sum;
        logic [SQ_W-1:0]  sq_sum;
    } t_lane_stats;

    localparam t_lane_stats STATS_INIT = '{
        err_min: {PIX_W{1'b1}},
        err_max: '0,
        err_sum: '0,
        sq_sum:  '0
    };

    typedef struct packed {
        logic [PIX_W-1:0]  err_min;
        logic [PIX_W-1:0]  err_max;
        logic [ESUM_W-1:0] err_sum;
        logic [SSUM_W-1:0] sq_sum;
    } t_total_stats;

    // output tdata layout, lowest field last
    typedef struct packed {
        logic              pad;
        logic [PTOT_W-1:0] pixel_total;
        logic [SSUM_W-1:0] square_sum;
        logic [ESUM_W-1:0] error_sum;
        logic [PIX_W-1:0]  max_error;
        logic [PIX_W-1:0]  min_error;
        logic [PIX_W-1:0]  diff_red;
        logic [PIX_W-1:0]  diff_green;
        logic [PIX_W-1:0]  diff_blue;
    } t_out_data;

    // green-yellow-red-white scale, returns {red, green, blue}
    function automatic logic [3*PIX_W-1:0] scale_color(input logic [PIX_W-1:0] e);
        logic [PIX_W-1:0] ramp;
        logic [3*PIX_W-1:0] rgb;
        ramp = {e[PIX_W-3:0], 2'b00};
        case (e[PIX_W-1:PIX_W-2])
            2'b00:   rgb = {8'd0, ramp, 8'd0};
            2'b01:   rgb = {ramp, 8'd255, 8'd0};
            2'b10:   rgb = {8'd255, ~ramp, 8'd0};
            2'b11:   rgb = {8'd255, ramp, ramp};
            default: rgb = '0;
        endcase
        return rgb;
    endfunction

endpackage

>>> rtl/ids_lane.sv
// ids_lane: one color channel - absolute difference, min/max, error and
// squared-error accumulators, and the snapshot taken on the last pixel.
// Depends on ids_pkg.

module ids_lane (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [ids_pkg::PIX_W-1:0]   i_first,
    input  logic [ids_pkg::PIX_W-1:0]   i_second,
    input  logic                        i_take,
    input  logic                        i_last,
    input  logic                        i_acc_en,
    output logic [ids_pkg::PIX_W-1:0]   o_err,
    output ids_pkg::t_lane_stats        o_stats
);
    import ids_pkg::*;

    logic [PIX_W-1:0]   w_err;
    logic [2*PIX_W-1:0] w_sq;
    t_lane_stats        w_upd;
    t_lane_stats        r_acc;
    t_lane_stats        n_acc;
    t_lane_stats        r_snap;

    always_comb begin
        w_err = (i_first > i_second) ? (i_first - i_second) : (i_second - i_first);
        w_sq  = w_err * w_err;

        w_upd = r_acc;
        if (i_acc_en) begin
            if (w_err < r_acc.err_min) begin
                w_upd.err_min = w_err;
            end
            if (w_err > r_acc.err_max) begin
                w_upd.err_max = w_err;
            end
            w_upd.err_sum = r_acc.err_sum + SUM_W'(w_err);
            w_upd.sq_sum  = r_acc.sq_sum + SQ_W'(w_sq);
        end

        n_acc = r_acc;
        if (i_take) begin
            n_acc = i_last ? STATS_INIT : w_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= STATS_INIT;
        end else begin
            r_acc <= n_acc;
        end
    end

    // image totals including the last pixel
    always_ff @(posedge i_clk) begin
        if (i_take && i_last) begin
            r_snap <= w_upd;
        end
    end

    assign o_err   = w_err;
    assign o_stats = r_snap;

endmodule

>>> rtl/ids_merge.sv
// ids_merge: combines the per-channel snapshots into the total record
// (min, max and sums over all channels), registered.
// Depends on ids_pkg.

module ids_merge (
    input  logic                   i_clk,
    input  ids_pkg::t_lane_stats   i_stats [ids_pkg::CHANNELS],
    output ids_pkg::t_total_stats  o_total
);
    import ids_pkg::*;

    t_total_stats w_total;
    t_total_stats r_total;

    always_comb begin
        w_total.err_min = {PIX_W{1'b1}};
        w_total.err_max = '0;
        w_total.err_sum = '0;
        w_total.sq_sum  = '0;
        for (int k = 0; k < CHANNELS; k++) begin
            if (i_stats[k].err_min < w_total.err_min) begin
                w_total.err_min = i_stats[k].err_min;
            end
            if (i_stats[k].err_max > w_total.err_max) begin
                w_total.err_max = i_stats[k].err_max;
            end
            w_total.err_sum = w_total.err_sum + ESUM_W'(i_stats[k].err_sum);
            w_total.sq_sum  = w_total.sq_sum + SSUM_W'(i_stats[k].sq_sum);
        end
    end

    // the snapshots are taken at the last pixel and the total over them is registered here
    always_ff @(posedge i_clk) begin
        r_total <= w_total;
    end

    assign o_total = r_total;

endmodule

>>> rtl/image_difference_statistics.sv
// image_difference_statistics: top level - input handshake, channel lanes,
// total merge, record sequencer and output register.
// Depends on ids_pkg, ids_lane, ids_merge.
//
// Usage:
//   s_axis carries one request per pixel pair: tdata holds first blue, green,
//   red, then second blue, green, red (8 bits each); tlast marks the last
//   pixel of the image pair. m_axis carries result records: tuser is the
//   record kind (pixel, blue, green, red, total), tlast marks the last record
//   caused by one request.
//   Every request yields one difference pixel record in the cycle after it is
//   accepted. A request with tlast also yields one statistics record per
//   channel and a total record after it; the accumulators start over with the
//   next image. While m_axis_tready is high, throughput is one pixel per cycle
//   and the single output register sends one record per cycle; after a last
//   pixel s_axis_tready stays low until the total record has been loaded.
//   The magnitude mode bit is to be written through i_cfg_wr_en/i_cfg_wr_data
//   only while the block is idle; the block itself does not enforce this.
//   Reset clears mode, the pixel and record counters, accumulators and the output valid flag.
//   When m_axis_tready is low the pending record holds and s_axis_tready
//   drops in the same cycle; nothing is lost.

module image_difference_statistics (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic                              i_cfg_wr_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // first_blue, first_green, first_red, second_blue, second_green, second_red
    input  logic [ids_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // diff_blue, diff_green, diff_red, min_error, max_error, error_sum,
    // square_sum, pixel_total, one zero pad bit
    output logic [ids_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // record_type
    output logic [ids_pkg::REC_W-1:0]         m_axis_tuser,
    output logic                              m_axis_tlast
);
    import ids_pkg::*;

    logic [PIX_W-1:0]   w_err [NSLOT];
    t_lane_stats        w_stats [CHANNELS];
    t_total_stats       w_total;
    logic [PIX_W-1:0]   w_peak;
    logic [3*PIX_W-1:0] w_rgb;
    logic               w_take;
    logic               w_out_free;
    logic               w_acc_en;
    logic [CNT_W-1:0]   w_cnt_upd;
    t_lane_stats        w_sel;

    logic               r_mag_mode;
    logic               r_out_valid, n_out_valid;
    t_out_data          r_out_data, n_out_data;
    logic [REC_W-1:0]   r_out_user, n_out_user;
    logic               r_out_last, n_out_last;
    logic               r_stats_busy, n_stats_busy;
    logic [IDX_W-1:0]   r_rec_idx, n_rec_idx;
    logic [CNT_W-1:0]   r_pix_cnt, n_pix_cnt;
    logic [CNT_W-1:0]   r_snap_cnt;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_out_free && !r_stats_busy;
    assign w_take        = s_axis_tvalid && s_axis_tready;
    assign w_acc_en      = r_pix_cnt < CNT_W'(MAX_PIXELS);
    assign w_cnt_upd     = r_pix_cnt + CNT_W'(w_acc_en);

    for (genvar g = 0; g < NSLOT; g++) begin : g_lane
        if (g < CHANNELS) begin : g_on
            logic [PIX_W-1:0] w_a;
            logic [PIX_W-1:0] w_b;
            if (g < COLORS) begin : g_in
                assign w_a = s_axis_tdata[g*PIX_W +: PIX_W];
                assign w_b = s_axis_tdata[(g+COLORS)*PIX_W +: PIX_W];
            end else begin : g_zero
                assign w_a = '0;
                assign w_b = '0;
            end
            ids_lane u_lane (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_first  (w_a),
                .i_second (w_b),
                .i_take   (w_take),
                .i_last   (s_axis_tlast),
                .i_acc_en (w_acc_en),
                .o_err    (w_err[g]),
                .o_stats  (w_stats[g])
            );
        end else begin : g_off
            assign w_err[g] = '0;
        end
    end

    ids_merge u_merge (
        .i_clk   (i_clk),
        .i_stats (w_stats),
        .o_total (w_total)
    );

    always_comb begin
        w_peak = '0;
        for (int k = 0; k < NSLOT; k++) begin
            if (w_err[k] > w_peak) begin
                w_peak = w_err[k];
            end
        end
        w_rgb = scale_color(w_peak);
    end

    assign w_sel = w_stats[r_rec_idx[LANE_W-1:0]];

    always_comb begin
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_data   = r_out_data;
        n_out_user   = r_out_user;
        n_out_last   = r_out_last;
        n_stats_busy = r_stats_busy;
        n_rec_idx    = r_rec_idx;
        n_pix_cnt    = r_pix_cnt;

        if (w_take) begin
            n_out_valid = 1'b1;
            n_out_data  = '0;
            n_out_user  = REC_PIXEL;
            n_out_last  = !s_axis_tlast;
            if (r_mag_mode) begin
                n_out_data.diff_red   = w_rgb[3*PIX_W-1:2*PIX_W];
                n_out_data.diff_green = w_rgb[2*PIX_W-1:PIX_W];
                n_out_data.diff_blue  = w_rgb[PIX_W-1:0];
            end else begin
                n_out_data.diff_blue  = w_err[0];
                n_out_data.diff_green = w_err[1];
                n_out_data.diff_red   = w_err[2];
            end
            n_pix_cnt = s_axis_tlast ? '0 : w_cnt_upd;
            if (s_axis_tlast) begin
                n_stats_busy = 1'b1;
                n_rec_idx    = '0;
            end
        end else if (r_stats_busy && w_out_free) begin
            n_out_valid = 1'b1;
            n_out_data  = '0;
            n_out_data.pixel_total = PTOT_W'(r_snap_cnt);
            if (r_rec_idx == IDX_W'(CHANNELS)) begin
                n_out_user             = REC_TOTAL;
                n_out_last             = 1'b1;
                n_out_data.min_error   = w_total.err_min;
                n_out_data.max_error   = w_total.err_max;
                n_out_data.error_sum   = w_total.err_sum;
                n_out_data.square_sum  = w_total.sq_sum;
                n_stats_busy           = 1'b0;
            end else begin
                n_out_user             = REC_BLUE + REC_W'(r_rec_idx);
                n_out_last             = 1'b0;
                n_out_data.min_error   = w_sel.err_min;
                n_out_data.max_error   = w_sel.err_max;
                n_out_data.error_sum   = ESUM_W'(w_sel.err_sum);
                n_out_data.square_sum  = SSUM_W'(w_sel.sq_sum);
                n_rec_idx              = r_rec_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag_mode   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_stats_busy <= 1'b0;
            r_rec_idx    <= '0;
            r_pix_cnt    <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mag_mode <= i_cfg_wr_data;
            end
            r_out_valid  <= n_out_valid;
            r_stats_busy <= n_stats_busy;
            r_rec_idx    <= n_rec_idx;
            r_pix_cnt    <= n_pix_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
        r_out_last <= n_out_last;
        if (w_take && s_axis_tlast) begin
            r_snap_cnt <= w_cnt_upd;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tlast  = r_out_last;

endmodule

>>> rtl/ids_checker.sv
// ids_checker: port-level checks of the image difference statistics block,
// attached to the top level by the bind below. Depends on ids_pkg.

module ids_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic                              s_axis_tlast,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [ids_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic [ids_pkg::REC_W-1:0]         m_axis_tuser,
    input  logic                              m_axis_tlast
);
    import ids_pkg::*;

    // a stalled record stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output record dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output data changed while stalled");

    // statistics records follow a last pixel, so no new request is taken right away
    a_stats_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("request taken while statistics records pending");

    a_total_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == REC_TOTAL |-> m_axis_tlast)
        else $error("total record not marked last");

    a_stats_no_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != REC_PIXEL |-> m_axis_tdata[3*PIX_W-1:0] == '0)
        else $error("statistics record carries difference bytes");

endmodule

bind image_difference_statistics ids_checker u_ids_checker (.*);
